// ===== src/stereo_video_payload_depacketizer_assert.svh =====
// Assertion macros used by the depacketizer top level.
`ifndef STEREO_VIDEO_PAYLOAD_DEPACKETIZER_ASSERT_SVH
`define STEREO_VIDEO_PAYLOAD_DEPACKETIZER_ASSERT_SVH

// Checked property on clk, ignored while rst is high.
`define SVPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property on clk, also checked during reset.
`define SVPD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/svpd_pkg.sv =====
// Package with the types and constants of the stereo video payload depacketizer.
package svpd_pkg;

  localparam int unsigned POS_W   = 15;
  localparam int unsigned FILL_W  = 18;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QLVL_W  = 3;

  localparam logic [FILL_W-1:0] FRAME_PIXELS     = 18'd153600;
  localparam logic [POS_W-1:0]  MAX_PACKET_BYTES = 15'd16384;
  localparam int unsigned       EOF_FLAG_BIT     = 1;

  typedef enum logic [1:0] {
    KIND_PAIR     = 2'd0,
    KIND_MID      = 2'd1,
    KIND_COMPLETE = 2'd2,
    KIND_SHORT    = 2'd3
  } result_kind_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       end_of_packet;
  } byte_req_t;

  typedef struct packed {
    result_kind_t      result_kind;
    logic [FILL_W-1:0] pixel_index;
    logic [7:0]        left_pixel;
    logic [7:0]        right_pixel;
    logic              stamp_changed;
    logic              last_result;
  } result_req_t;

  // Results produced by one byte, handed from the core to the queue.
  typedef struct packed {
    logic [1:0]  count;
    result_req_t res0;
    result_req_t res1;
  } push_t;

endpackage

// ===== src/svpd_core.sv =====
// Input register, header parsing, pixel pairing and status generation.
module svpd_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 byte_valid,
  output logic                                 byte_stall,
  input  svpd_pkg::byte_req_t                  byte_req,
  input  logic                                 room,
  output svpd_pkg::push_t                      push
);
  import svpd_pkg::*;

  // Input register.
  logic      in_full;
  byte_req_t in_data;
  logic      process;
  logic      accept;

  // Packet and frame state.
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]        header_length, header_length_next;
  logic [7:0]        header_flags, header_flags_next;
  logic [31:0]       packet_stamp, packet_stamp_next;
  logic [31:0]       frame_stamp, frame_stamp_next;
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic [7:0]        held_left_byte, held_left_byte_next;
  logic              holding_left, holding_left_next;

  logic       take;
  logic       pair;
  logic       holding_eff;
  logic       in_stamp;
  logic [1:0] lane;
  logic [7:0] b;
  logic       eop;
  result_req_t pair_res;
  result_req_t stat_res;

  assign process    = in_full && room;
  assign byte_stall = in_full && !process;
  assign accept     = byte_valid && !byte_stall;
  assign b          = in_data.packet_byte;
  assign eop        = in_data.end_of_packet;

  // Input register: holds one byte until the result queue has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data <= byte_req;
    end
  end

  // Per-byte parsing and result generation.
  always_comb begin
    byte_position_next  = byte_position;
    header_length_next  = header_length;
    header_flags_next   = header_flags;
    packet_stamp_next   = packet_stamp;
    frame_stamp_next    = frame_stamp;
    fill_count_next     = fill_count;
    held_left_byte_next = held_left_byte;
    holding_left_next   = holding_left;
    holding_eff         = holding_left;
    pair                = 1'b0;
    in_stamp            = 1'b0;
    lane                = byte_position[1:0] + 2'd2;

    pair_res               = '0;
    pair_res.result_kind   = KIND_PAIR;
    stat_res               = '0;
    stat_res.result_kind   = KIND_MID;
    stat_res.last_result   = 1'b1;

    // Header fields; byte 0 opens a new packet.
    if (byte_position == '0) begin
      header_length_next = b;
      header_flags_next  = '0;
      packet_stamp_next  = '0;
      holding_eff        = 1'b0;
    end else if (byte_position == 15'd1) begin
      header_flags_next = b;
    end else if (byte_position <= 15'd5) begin
      in_stamp = 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      if (in_stamp && (lane == 2'(i))) begin
        packet_stamp_next[8*i +: 8] = packet_stamp[8*i +: 8] | b;
      end
    end
    holding_left_next = holding_eff;

    // Payload bytes are paired into left and right pixels.
    take = (byte_position < MAX_PACKET_BYTES) &&
           (byte_position >= {{(POS_W-8){1'b0}}, header_length_next});
    if (take) begin
      if (!holding_eff) begin
        held_left_byte_next = b;
        holding_left_next   = 1'b1;
      end else begin
        holding_left_next = 1'b0;
        if (fill_count < FRAME_PIXELS) begin
          pair                 = 1'b1;
          pair_res.pixel_index = fill_count;
          pair_res.left_pixel  = held_left_byte;
          pair_res.right_pixel = b;
          pair_res.last_result = !eop;
          fill_count_next      = fill_count + 18'd1;
        end
      end
    end

    // End of packet: frame status or timestamp report.
    stat_res.pixel_index = fill_count_next;
    if (eop) begin
      if (header_flags_next[EOF_FLAG_BIT]) begin
        stat_res.result_kind = (fill_count_next == FRAME_PIXELS) ? KIND_COMPLETE : KIND_SHORT;
        fill_count_next      = '0;
        frame_stamp_next     = '0;
      end else begin
        stat_res.stamp_changed = (frame_stamp != '0) && (packet_stamp_next != frame_stamp);
        frame_stamp_next       = packet_stamp_next;
      end
      byte_position_next = '0;
      holding_left_next  = 1'b0;
    end else if (byte_position < MAX_PACKET_BYTES) begin
      byte_position_next = byte_position + 15'd1;
    end

    // Results handed to the queue, pair first.
    push       = '0;
    push.count = process ? ({1'b0, pair} + {1'b0, eop}) : 2'd0;
    push.res0  = pair ? pair_res : stat_res;
    push.res1  = stat_res;
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      header_length  <= '0;
      header_flags   <= '0;
      packet_stamp   <= '0;
      frame_stamp    <= '0;
      fill_count     <= '0;
      held_left_byte <= '0;
      holding_left   <= 1'b0;
    end else if (process) begin
      byte_position  <= byte_position_next;
      header_length  <= header_length_next;
      header_flags   <= header_flags_next;
      packet_stamp   <= packet_stamp_next;
      frame_stamp    <= frame_stamp_next;
      fill_count     <= fill_count_next;
      held_left_byte <= held_left_byte_next;
      holding_left   <= holding_left_next;
    end
  end

endmodule

// ===== src/svpd_queue.sv =====
// Result queue that takes up to two results per cycle and sends one while result_stall is low.
module svpd_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  svpd_pkg::push_t                  push,
  output logic                             room,
  output logic [svpd_pkg::QLVL_W-1:0]      level,
  output logic                             result_valid,
  input  logic                             result_stall,
  output svpd_pkg::result_req_t            result_req
);
  import svpd_pkg::*;

  result_req_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;

  assign result_valid = (level != '0);
  assign pop          = result_valid && !result_stall;
  assign room         = (level <= QLVL_W'(QUEUE_DEPTH - 2));
  assign result_req   = entries[rd_ptr];

  // Entry writes.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.res1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      level <= level + QLVL_W'(push.count) - QLVL_W'(pop);
    end
  end

endmodule

// ===== src/stereo_video_payload_depacketizer.sv =====
// Top level of the stereo video payload depacketizer.
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------
//  byte     | byte_valid, byte_stall, byte_req | one payload byte and its end flag
//  result   | result_valid, result_stall,      | one pixel pair or packet status
//           | result_req                       |
//
// One byte is taken per cycle while byte_stall is low; it is held in the input
// register and its results are written into the queue behind the result channel.
// A byte that completes a pixel pair and closes a packet gives two results, which
// leave the four-entry result queue one after the other.
// The input register holds its byte while the queue has fewer than two free
// entries, and the byte channel stalls only then.
// Synchronous reset clears the packet state, fill count and queue.
module stereo_video_payload_depacketizer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  svpd_pkg::byte_req_t    byte_req,
  output logic                   result_valid,
  input  logic                   result_stall,
  output svpd_pkg::result_req_t  result_req
);
  import svpd_pkg::*;
  `include "stereo_video_payload_depacketizer_assert.svh"

  push_t             push;
  logic              room;
  logic [QLVL_W-1:0] level;
  logic              two_marked;
  logic              pair_out;
  logic              pair_index_ok;
  logic              last_leaves;

  svpd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req),
    .room       (room),
    .push       (push)
  );

  svpd_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .level        (level),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_req   (result_req)
  );

  // Terms used by the checks below.
  assign two_marked    = !push.res0.last_result && push.res1.last_result &&
                         (push.res0.result_kind == KIND_PAIR);
  assign pair_out      = result_valid && (result_req.result_kind == KIND_PAIR);
  assign pair_index_ok = (result_req.pixel_index < FRAME_PIXELS);
  assign last_leaves   = result_valid && !result_stall && (level == QLVL_W'(1)) &&
                         (push.count == 2'd0);

  // The queue never overfills.
  `SVPD_ASSERT(a_level_bound, level <= QLVL_W'(QUEUE_DEPTH), "result queue overflow")

  // A byte with two results marks only the second as last.
  `SVPD_ASSERT(a_two_results_last, (push.count == 2'd2) |-> two_marked, "bad last marks")

  // Pixel pairs never index past the frame.
  `SVPD_ASSERT(a_pair_index, pair_out |-> pair_index_ok, "pixel index out of frame")

  // The last queued request leaves and nothing arrives: the queue goes empty.
  `SVPD_ASSERT(a_drain, last_leaves |=> !result_valid, "queue did not drain")

endmodule
